[rtl/core/multi_alarm_elapsed_timer_defines.svh]
// Assertion macros used by the alarm timer checker.
`ifndef MULTI_ALARM_ELAPSED_TIMER_DEFINES_SVH
`define MULTI_ALARM_ELAPSED_TIMER_DEFINES_SVH

// Same-cycle implication, sampled on clk, masked while rst is high.
`define MAE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, masked while rst is high.
`define MAE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/mae_pkg.sv]
// Shared types and constants of the multi-alarm elapsed timer.
package mae_pkg;

  localparam int ALARM_SLOTS_DEFAULT = 16;

  localparam int TIME_W = 17;
  localparam int DUE_W  = 32;
  localparam int TAG_W  = 8;
  localparam int HOUR_W = 5;
  localparam int MS_W   = 6;
  localparam int CNT_OUT_W = 5;

  localparam logic [TIME_W-1:0] DAY_SECONDS   = 17'd86400;
  localparam logic [TIME_W-1:0] LAST_SECOND   = 17'd86399;
  localparam logic [TIME_W-1:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [TIME_W-1:0] SECS_PER_MIN  = 17'd60;
  localparam logic [HOUR_W-1:0] MAX_HOUR      = 5'd23;
  localparam logic [MS_W-1:0]   MAX_MIN_SEC   = 6'd59;

  typedef enum logic {
    OP_SET   = 1'b0,
    OP_CHECK = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    STAT_ADDED   = 3'd0,
    STAT_INVALID = 3'd1,
    STAT_FULL    = 3'd2,
    STAT_FIRED   = 3'd3,
    STAT_DONE    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADVANCE,
    S_SET_STORE,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic [DUE_W-1:0] due;
    logic [TAG_W-1:0] tag;
  } slot_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

[rtl/core/mae_cell.sv]
// One alarm slot: holds a due time and tag, loads or takes its neighbour's entry.
module mae_cell (
  input  logic               clk,
  input  mae_pkg::cell_ctrl_t ctrl,
  input  mae_pkg::slot_t     neighbour,
  input  mae_pkg::slot_t     load_slot,
  output mae_pkg::slot_t     slot
);

  // Load wins over shift: a kept entry lands in the cell it is shifted past.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      slot <= load_slot;
    end else if (ctrl.shift) begin
      slot <= neighbour;
    end
  end

endmodule

[rtl/core/mae_chain.sv]
// Row of alarm slot cells in insertion order, head at cell zero.
module mae_chain #(
  parameter int ALARM_SLOTS = mae_pkg::ALARM_SLOTS_DEFAULT,
  parameter int IDX_W       = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1
) (
  input  logic                clk,
  input  mae_pkg::cell_ctrl_t cmd,
  input  logic [IDX_W-1:0]    load_idx,
  input  mae_pkg::slot_t      load_slot,
  output mae_pkg::slot_t      head
);

  mae_pkg::slot_t row [ALARM_SLOTS];

  for (genvar i = 0; i < ALARM_SLOTS; i++) begin : g_cell
    mae_pkg::cell_ctrl_t ctrl;
    mae_pkg::slot_t      neighbour;

    assign ctrl.shift = cmd.shift;
    assign ctrl.load  = cmd.load && (load_idx == IDX_W'(i));

    if (i == ALARM_SLOTS - 1) begin : g_tail
      assign neighbour = '0;
    end else begin : g_body
      assign neighbour = row[i+1];
    end

    mae_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .neighbour (neighbour),
      .load_slot (load_slot),
      .slot      (row[i])
    );
  end

  assign head = row[0];

endmodule

[rtl/core/multi_alarm_elapsed_timer.sv]
// Top level of the multi-alarm elapsed timer: control, time keeping and result register.
//
// Input channel (s_axis_*): one transaction per command. tuser is the operation
// (set or check); tdata carries the time of day and, for a set, hh:mm:ss and a tag.
// Output channel (m_axis_*): result transactions; tuser is the status code and
// tlast marks the final result caused by one command.
//
// Timing: the block takes one command at a time. A set, or a rejected command,
// is accepted in S_IDLE and evaluated in S_ADVANCE; a valid set then stores its
// alarm in S_SET_STORE once the result register is free. A check advances the time
// in S_ADVANCE, then steps the slot row once per stored alarm in S_SCAN, then issues
// its done result. The slot scan is the limiting loop: the row shifts one place per
// cycle towards the head cell, except while a due alarm waits for the output register.
//
// Results leave through a single output register, so a waiting result does not
// block the next command from being accepted. When the receiver stalls, the scan
// holds at the first alarm that is due until the register frees up.
//
// Reset (rst, synchronous): clears the control state, the elapsed counter, the
// time reference and the alarm count. Slot contents are not cleared; only
// slots below the alarm count are ever read.
module multi_alarm_elapsed_timer #(
  parameter int ALARM_SLOTS = mae_pkg::ALARM_SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [16:0] now_seconds, [21:17] alarm_hour, [27:22] alarm_minute,
  // [33:28] alarm_second, [41:34] alarm_tag, [47:42] zero
  input  logic [47:0] s_axis_tdata,
  // [0] operation
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] fired_tag, [24:8] seconds_until, [29:25] active_count, [31:30] zero
  output logic [31:0] m_axis_tdata,
  // [2:0] status
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  localparam int CNT_W = $clog2(ALARM_SLOTS + 1);
  localparam int IDX_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
  localparam int TW    = mae_pkg::TIME_W;
  localparam int DW    = mae_pkg::DUE_W;
  localparam int GW    = mae_pkg::TAG_W;

  // Control state
  mae_pkg::state_t state, state_next;
  logic             prev_valid;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] scan_left;

  // Command and time registers
  mae_pkg::op_t             op_q;
  logic [TW-1:0]            now_q;
  logic [mae_pkg::HOUR_W-1:0] hour_q;
  logic [mae_pkg::MS_W-1:0] minute_q;
  logic [mae_pkg::MS_W-1:0] second_q;
  logic [GW-1:0]            tag_q;
  logic [TW-1:0]            target_q;
  logic [TW-1:0]            until_q;
  logic [DW-1:0]            elapsed;
  logic [TW-1:0]            prev_time;

  // Input field views
  logic [TW-1:0]              in_now;
  logic [TW-1:0]              in_now_clamped;
  logic [mae_pkg::HOUR_W-1:0] in_hour;
  logic [mae_pkg::MS_W-1:0]   in_minute;
  logic [mae_pkg::MS_W-1:0]   in_second;
  logic [TW-1:0]              in_target;
  logic                       in_fire;

  // Datapath intermediates
  logic [TW-1:0]   delta;
  logic [DW:0]     elapsed_sum;
  logic [DW-1:0]   elapsed_adv;
  logic [TW-1:0]   until_calc;
  logic [DW:0]     due_sum;
  logic [DW-1:0]   due_sat;
  logic            time_bad;
  logic            table_full;
  logic            head_due;
  logic [CNT_W-1:0] count_less;
  logic            out_free;

  // Strobes from the control block
  logic            do_advance;
  logic            clear_on_set;
  logic            count_inc;
  logic            count_dec;
  logic            scan_step;
  logic            scan_end;
  logic            emit;
  mae_pkg::status_t emit_status;
  logic [GW-1:0]   emit_tag;
  logic [TW-1:0]   emit_until;
  logic [CNT_W-1:0] emit_count;
  logic            emit_last;

  // Slot row interface
  mae_pkg::cell_ctrl_t chain_cmd;
  logic [IDX_W-1:0]    load_idx;
  mae_pkg::slot_t      load_slot;
  mae_pkg::slot_t      head;

  // Unpack the command and clamp the time of day to the last second of a day
  assign in_now    = s_axis_tdata[16:0];
  assign in_hour   = s_axis_tdata[21:17];
  assign in_minute = s_axis_tdata[27:22];
  assign in_second = s_axis_tdata[33:28];
  assign in_now_clamped = (in_now > mae_pkg::LAST_SECOND) ? mae_pkg::LAST_SECOND : in_now;

  // Target second of day; fits 17 bits even for out-of-range fields
  assign in_target = TW'(in_hour) * mae_pkg::SECS_PER_HOUR
                   + TW'(in_minute) * mae_pkg::SECS_PER_MIN
                   + TW'(in_second);

  assign s_axis_tready = (state == mae_pkg::S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // Elapsed advance, taking the difference across midnight when time steps back
  assign delta = (now_q >= prev_time) ? (now_q - prev_time)
                                      : (mae_pkg::DAY_SECONDS - prev_time + now_q);
  assign elapsed_sum = {1'b0, elapsed} + (DW + 1)'(delta);
  assign elapsed_adv = elapsed_sum[DW] ? '1 : elapsed_sum[DW-1:0];

  // Delay to the alarm: same day, or next day when the time has already passed
  assign until_calc = (now_q > target_q) ? (mae_pkg::DAY_SECONDS - now_q + target_q)
                                         : (target_q - now_q);

  assign due_sum = {1'b0, elapsed} + (DW + 1)'(until_q);
  assign due_sat = due_sum[DW] ? '1 : due_sum[DW-1:0];

  assign time_bad   = (hour_q > mae_pkg::MAX_HOUR) || (minute_q > mae_pkg::MAX_MIN_SEC)
                   || (second_q > mae_pkg::MAX_MIN_SEC);
  assign table_full = (count == CNT_W'(ALARM_SLOTS));
  assign head_due   = (head.due <= elapsed);
  assign count_less = count - CNT_W'(1);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mae_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, strobes and slot row control
  always_comb begin
    state_next   = state;
    do_advance   = 1'b0;
    clear_on_set = 1'b0;
    count_inc    = 1'b0;
    count_dec    = 1'b0;
    scan_step    = 1'b0;
    scan_end     = 1'b0;
    emit         = 1'b0;
    emit_status  = mae_pkg::STAT_DONE;
    emit_tag     = '0;
    emit_until   = '0;
    emit_count   = count;
    emit_last    = 1'b1;
    chain_cmd    = '0;
    load_idx     = count[IDX_W-1:0];
    load_slot.due = due_sat;
    load_slot.tag = tag_q;

    unique case (state)
      mae_pkg::S_IDLE: begin
        if (in_fire) begin
          state_next = mae_pkg::S_ADVANCE;
        end
      end

      mae_pkg::S_ADVANCE: begin
        if (op_q == mae_pkg::OP_SET && (time_bad || table_full)) begin
          // Rejected set: report only, no time sample, no state change
          if (out_free) begin
            emit        = 1'b1;
            emit_status = time_bad ? mae_pkg::STAT_INVALID : mae_pkg::STAT_FULL;
            state_next  = mae_pkg::S_IDLE;
          end
        end else begin
          do_advance = 1'b1;
          if (op_q == mae_pkg::OP_SET) begin
            clear_on_set = (count == '0);
            state_next   = mae_pkg::S_SET_STORE;
          end else begin
            state_next = mae_pkg::S_SCAN;
          end
        end
      end

      mae_pkg::S_SET_STORE: begin
        if (out_free) begin
          chain_cmd.load = 1'b1;
          count_inc      = 1'b1;
          emit           = 1'b1;
          emit_status    = mae_pkg::STAT_ADDED;
          emit_until     = until_q;
          emit_count     = count + CNT_W'(1);
          state_next     = mae_pkg::S_IDLE;
        end
      end

      mae_pkg::S_SCAN: begin
        if (scan_left == '0) begin
          if (out_free) begin
            emit       = 1'b1;
            scan_end   = 1'b1;
            state_next = mae_pkg::S_IDLE;
          end
        end else if (head_due) begin
          // Fire and drop the head entry; hold while the result cannot leave
          if (out_free) begin
            chain_cmd.shift = 1'b1;
            count_dec       = 1'b1;
            scan_step       = 1'b1;
            emit            = 1'b1;
            emit_status     = mae_pkg::STAT_FIRED;
            emit_tag        = head.tag;
            emit_count      = count_less;
            emit_last       = 1'b0;
          end
        end else begin
          // Not yet due: rotate the head entry behind the stored alarms
          chain_cmd.shift = 1'b1;
          chain_cmd.load  = 1'b1;
          load_idx        = count_less[IDX_W-1:0];
          load_slot       = head;
          scan_step       = 1'b1;
        end
      end

      default: begin
        state_next = mae_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_valid <= 1'b0;
      count      <= '0;
      scan_left  <= '0;
      elapsed    <= '0;
      prev_time  <= '0;
    end else begin
      if (do_advance) begin
        if (clear_on_set) begin
          elapsed <= '0;
        end else if (prev_valid) begin
          elapsed <= elapsed_adv;
        end
        prev_time  <= now_q;
        prev_valid <= 1'b1;
        scan_left  <= count;
      end
      if (count_inc) begin
        count <= count + CNT_W'(1);
      end else if (count_dec) begin
        count <= count_less;
      end
      if (scan_step) begin
        scan_left <= scan_left - CNT_W'(1);
      end
      // Table left empty after a check: drop the elapsed count and time reference
      if (scan_end && count == '0) begin
        elapsed    <= '0;
        prev_valid <= 1'b0;
      end
    end
  end

  // Command payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q     <= mae_pkg::op_t'(s_axis_tuser);
      now_q    <= in_now_clamped;
      hour_q   <= in_hour;
      minute_q <= in_minute;
      second_q <= in_second;
      tag_q    <= s_axis_tdata[41:34];
      target_q <= in_target;
    end
    if (state == mae_pkg::S_ADVANCE) begin
      until_q <= until_calc;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_axis_tdata <= {2'b00, mae_pkg::CNT_OUT_W'(emit_count), emit_until, emit_tag};
      m_axis_tuser <= emit_status;
      m_axis_tlast <= emit_last;
    end
  end

  mae_chain #(
    .ALARM_SLOTS (ALARM_SLOTS),
    .IDX_W       (IDX_W)
  ) u_chain (
    .clk       (clk),
    .cmd       (chain_cmd),
    .load_idx  (load_idx),
    .load_slot (load_slot),
    .head      (head)
  );

endmodule

[rtl/core/mae_checker.sv]
// Port-level checker for the multi-alarm elapsed timer, bound to the top level.
`include "multi_alarm_elapsed_timer_defines.svh"

module mae_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // A stalled result holds its payload
  `MAE_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  // Only a fired alarm continues a run; every other status closes it
  `MAE_ASSERT_NOW(a_last_code, clk, rst, m_axis_tvalid, m_axis_tlast == (m_axis_tuser != mae_pkg::STAT_FIRED), "tlast does not match status")

  // A delay is reported only for an added alarm, a tag only for a fired one
  `MAE_ASSERT_NOW(a_field_zero, clk, rst, m_axis_tvalid, (m_axis_tuser == mae_pkg::STAT_ADDED || m_axis_tdata[24:8] == '0) && (m_axis_tuser == mae_pkg::STAT_FIRED || m_axis_tdata[7:0] == '0), "unexpected non-zero field")

  // A new command is not taken in the cycle after one was accepted
  `MAE_ASSERT_NEXT(a_one_at_time, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "command accepted while busy")

endmodule

bind multi_alarm_elapsed_timer mae_checker u_mae_checker (.*);

[tb/tb_multi_alarm_elapsed_timer.sv]
// Self-checking testbench for the multi-alarm elapsed timer.
`timescale 1ns / 1ps

module tb_multi_alarm_elapsed_timer;

  localparam int SLOTS      = 16;
  localparam int HOLD_OFF   = 400;   // long receiver stall, in cycles
  localparam int DRAIN_WAIT = 60;    // wait after the last expected result, long enough for a full check

  // One command as offered on the input stream
  typedef struct packed {
    mae_pkg::op_t op;
    logic [16:0]  now;
    logic [4:0]   hh;
    logic [5:0]   mm;
    logic [5:0]   ss;
    logic [7:0]   tag;
  } alarm_cmd_t;

  // One result as seen on the output stream
  typedef struct packed {
    mae_pkg::status_t status;
    logic [7:0]       fired_tag;
    logic [16:0]      secs_until;
    logic [4:0]       count;
    logic             is_last;
  } alarm_result_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE,
    RDY_EVERY_THIRD
  } stall_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        hold_active = 1'b0;

  // Stimulus and expectations
  alarm_cmd_t    alarm_cmds[$];
  alarm_result_t expected_results[$];
  alarm_cmd_t    cur_cmd;

  // Predictor state: elapsed counter, time reference and the alarm row
  logic [31:0] elapsed_cnt;
  logic [16:0] sample_time;
  logic        sample_valid;
  logic [31:0] slot_due[SLOTS];
  logic [7:0]  slot_tag[SLOTS];
  int          slot_fill;

  // Bookkeeping
  int errors       = 0;
  int cmds_taken   = 0;
  int results_seen = 0;
  int n_added      = 0;
  int n_fired      = 0;
  int n_rejected   = 0;
  int n_checks     = 0;
  int burst_left   = 0;
  int gap_left     = 0;
  int hold_left    = 0;
  bit hold_done    = 0;
  int mode_left    = 0;
  int phase        = 0;
  stall_mode_t rx_mode = RDY_ALWAYS;

  multi_alarm_elapsed_timer i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $display("timeout at %0t: %0d commands left, %0d results outstanding",
             $time, alarm_cmds.size(), expected_results.size());
    $finish;
  end

  task automatic queue_cmd(input mae_pkg::op_t op, input int now, input int hh, input int mm,
                           input int ss, input int tag);
    alarm_cmd_t c;
    c.op  = op;
    c.now = now[16:0];
    c.hh  = hh[4:0];
    c.mm  = mm[5:0];
    c.ss  = ss[5:0];
    c.tag = tag[7:0];
    alarm_cmds.push_back(c);
  endtask

  // Fold a new time-of-day sample into the elapsed counter; wrap across midnight
  task automatic advance_elapsed(input logic [16:0] now);
    longint unsigned delta;
    longint unsigned sum;
    if (sample_valid) begin
      if (now >= sample_time) delta = now - sample_time;
      else delta = mae_pkg::DAY_SECONDS - sample_time + now;
      sum = elapsed_cnt + delta;
      elapsed_cnt = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
    end
    sample_time  = now;
    sample_valid = 1'b1;
  endtask

  task automatic predict_alarm_results(input alarm_cmd_t c);
    logic [16:0]     now;
    int unsigned     target;
    int unsigned     secs;
    longint unsigned due;
    int              i;
    alarm_result_t   r;
    now = (c.now > mae_pkg::LAST_SECOND) ? mae_pkg::LAST_SECOND : c.now;
    r = '{status: mae_pkg::STAT_ADDED, fired_tag: 8'd0, secs_until: 17'd0,
          count: 5'(slot_fill), is_last: 1'b1};
    if (c.op == mae_pkg::OP_SET) begin
      if (c.hh > mae_pkg::MAX_HOUR || c.mm > mae_pkg::MAX_MIN_SEC ||
          c.ss > mae_pkg::MAX_MIN_SEC) begin
        r.status = mae_pkg::STAT_INVALID;
      end else if (slot_fill >= SLOTS) begin
        r.status = mae_pkg::STAT_FULL;
      end else begin
        advance_elapsed(now);
        if (slot_fill == 0) elapsed_cnt = '0;
        target = c.hh * 3600 + c.mm * 60 + c.ss;
        secs = (now > target) ? mae_pkg::DAY_SECONDS - now + target : target - now;
        due = elapsed_cnt + secs;
        slot_due[slot_fill] = (due > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : due[31:0];
        slot_tag[slot_fill] = c.tag;
        slot_fill++;
        r.secs_until = secs[16:0];
        r.count = 5'(slot_fill);
      end
      expected_results.push_back(r);
    end else begin
      advance_elapsed(now);
      i = 0;
      // Fire in insertion order, closing up the row behind each removed alarm
      while (i < slot_fill) begin
        if (slot_due[i] <= elapsed_cnt) begin
          r = '{status: mae_pkg::STAT_FIRED, fired_tag: slot_tag[i], secs_until: 17'd0,
                count: 5'(slot_fill - 1), is_last: 1'b0};
          for (int k = i; k < slot_fill - 1; k++) begin
            slot_due[k] = slot_due[k+1];
            slot_tag[k] = slot_tag[k+1];
          end
          slot_fill--;
          expected_results.push_back(r);
        end else begin
          i++;
        end
      end
      // An emptied table forgets both the counter and the time reference
      if (slot_fill == 0) begin
        elapsed_cnt  = '0;
        sample_valid = 1'b0;
      end
      r = '{status: mae_pkg::STAT_DONE, fired_tag: 8'd0, secs_until: 17'd0,
            count: 5'(slot_fill), is_last: 1'b1};
      expected_results.push_back(r);
    end
  endtask

  // Sender: bursts of back-to-back transactions separated by random gaps.
  // Predict at the edge where a transaction is taken.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      elapsed_cnt   = '0;
      sample_time   = '0;
      sample_valid  = 1'b0;
      slot_fill     = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_alarm_results(cur_cmd);
        cmds_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        // keep offering during the long stall so the input backs up
        if (gap_left > 0 && !hold_active) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (alarm_cmds.size() > 0) begin
          cur_cmd = alarm_cmds.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= cur_cmd.op;
          s_axis_tdata  <= {6'd0, cur_cmd.tag, cur_cmd.ss, cur_cmd.mm, cur_cmd.hh,
                            cur_cmd.now};
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 8);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result against the oldest expectation, then pick
  // the next ready value from the current stall pattern
  always @(posedge clk) begin
    alarm_result_t got;
    alarm_result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_active   <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{status: mae_pkg::status_t'(m_axis_tuser), fired_tag: m_axis_tdata[7:0],
                secs_until: m_axis_tdata[24:8], count: m_axis_tdata[29:25],
                is_last: m_axis_tlast};
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, actual status=%0d tag=%0d until=%0d",
                   $time, got.status, got.fired_tag, got.secs_until);
          $display("%0t:           actual count=%0d last=%0b",
                   $time, got.count, got.is_last);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.fired_tag !== want.fired_tag ||
              got.secs_until !== want.secs_until || got.count !== want.count ||
              got.is_last !== want.is_last) begin
            errors++;
            $display("%0t: mismatch, expected status=%0d tag=%0d until=%0d count=%0d last=%0b",
                     $time, want.status, want.fired_tag, want.secs_until, want.count,
                     want.is_last);
            $display("%0t:           actual status=%0d tag=%0d until=%0d count=%0d last=%0b",
                     $time, got.status, got.fired_tag, got.secs_until, got.count,
                     got.is_last);
          end
          case (want.status)
            mae_pkg::STAT_ADDED: n_added++;
            mae_pkg::STAT_FIRED: n_fired++;
            mae_pkg::STAT_DONE:  n_checks++;
            default:             n_rejected++;
          endcase
        end
      end

      // One long hold-off once traffic is under way
      if (!hold_done && results_seen >= 60) begin
        hold_left = HOLD_OFF;
        hold_done = 1;
      end
      if (mode_left == 0) begin
        rx_mode   = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      phase++;

      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RDY_ALWAYS:  m_axis_tready <= 1'b1;
          RDY_COIN:    m_axis_tready <= $urandom_range(0, 1);
          RDY_SPARSE:  m_axis_tready <= ($urandom_range(0, 3) == 0);
          default:     m_axis_tready <= (phase % 3 == 0);
        endcase
      end
      hold_active <= (hold_left > 0);
    end
  end

  // Build the stimulus, then wait for the block to drain and report
  initial begin
    int wall;
    int now_f;
    int n;
    int roll;
    int off;
    int target;
    int hh;
    int mm;
    int ss;
    int runs;

    // Check on an empty table
    queue_cmd(mae_pkg::OP_CHECK, 100, 0, 0, 0, 0);
    // Time above the last second of the day; alarm at midnight is one second away
    queue_cmd(mae_pkg::OP_SET, 17'h1FFFF, 0, 0, 0, 8'hFF);
    // Out-of-range hour, minute and second, each alone at the field maximum, then an hour just past the range
    queue_cmd(mae_pkg::OP_SET, 500, 31, 0, 0, 8'h11);
    queue_cmd(mae_pkg::OP_SET, 500, 0, 63, 0, 8'h22);
    queue_cmd(mae_pkg::OP_SET, 500, 0, 0, 63, 8'h33);
    queue_cmd(mae_pkg::OP_SET, 500, 24, 59, 59, 8'h44);
    // Alarm at exactly the current second
    queue_cmd(mae_pkg::OP_SET, 86399, 23, 59, 59, 8'hA5);
    // Clock steps back across midnight
    queue_cmd(mae_pkg::OP_SET, 0, 0, 0, 0, 8'h5A);
    // Fires all three and leaves the table empty
    queue_cmd(mae_pkg::OP_CHECK, 0, 0, 0, 0, 0);
    // Fill every slot, then one more set to hit the full table
    for (int k = 0; k < SLOTS; k++) begin
      target = 1000 + $urandom_range(0, 3000);
      queue_cmd(mae_pkg::OP_SET, 1000, target / 3600, (target % 3600) / 60, target % 60,
                k * 16 + k);
    end
    queue_cmd(mae_pkg::OP_SET, 1000, 12, 0, 0, 8'h77);

    // Random part: a wall clock that mostly moves forward, with alarms set
    // a little ahead of it so that later checks see them fire
    wall = 1000;
    n = 0;
    while (n < 84) begin
      runs = ($urandom_range(0, 24) == 0) ? SLOTS + 1 : 1;
      for (int r = 0; r < runs; r++) begin
        roll = $urandom_range(0, 99);
        if (runs > 1) wall = (wall + $urandom_range(0, 30)) % 86400;
        else if (roll < 60) wall = (wall + $urandom_range(0, 600)) % 86400;
        else if (roll < 88) wall = (wall + $urandom_range(0, 20000)) % 86400;
        else if (roll < 95) wall = $urandom_range(0, 86399);
        now_f = wall;
        if (roll >= 95) begin
          now_f = $urandom_range(86400, 131071);
          wall  = 86399;
        end

        if (runs == 1 && $urandom_range(0, 99) < 45) begin
          queue_cmd(mae_pkg::OP_CHECK, now_f, $urandom_range(0, 31),
                    $urandom_range(0, 63), $urandom_range(0, 63),
                    $urandom_range(0, 255));
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 50) off = $urandom_range(0, 1800);
          else if (roll < 80) off = $urandom_range(0, 20000);
          else off = $urandom_range(0, 86399);
          target = (wall + off) % 86400;
          hh = target / 3600;
          mm = (target % 3600) / 60;
          ss = target % 60;
          if (runs == 1 && $urandom_range(0, 99) < 15) begin
            case ($urandom_range(0, 2))
              0:       hh = $urandom_range(24, 31);
              1:       mm = $urandom_range(60, 63);
              default: ss = $urandom_range(60, 63);
            endcase
          end
          queue_cmd(mae_pkg::OP_SET, now_f, hh, mm, ss, $urandom_range(0, 255));
        end
        n++;
      end
    end

    do @(negedge clk);
    while (alarm_cmds.size() > 0 || s_axis_tvalid || expected_results.size() > 0);
    repeat (DRAIN_WAIT) @(negedge clk);

    if (expected_results.size() > 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, expected_results.size());
    end
    $display("Ran %0d commands into %0d results: %0d alarms added, %0d fired, %0d checks",
             cmds_taken, results_seen, n_added, n_fired, n_checks);
    $display("%0d sets rejected as out of range or table full, %0d errors",
             n_rejected, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/mae_pkg.sv
rtl/core/mae_cell.sv
rtl/core/mae_chain.sv
rtl/core/multi_alarm_elapsed_timer.sv
rtl/core/mae_checker.sv
tb/tb_multi_alarm_elapsed_timer.sv
